// ===== design/pulse_interval_window_counter_assert.svh =====
// assertion macros for the pulse interval window counter
`ifndef PULSE_INTERVAL_WINDOW_COUNTER_ASSERT_SVH
`define PULSE_INTERVAL_WINDOW_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIVWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pivwc assertion failed");

// next-cycle implication, checked outside reset
`define PIVWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pivwc assertion failed");

`endif

// ===== design/pivwc_pkg.sv =====
`timescale 1ns / 1ps

package pivwc_pkg;

    localparam int RING_DEPTH = 128;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int STORED_W   = $clog2(RING_DEPTH + 1);
    localparam int TIME_BITS  = 32;
    localparam int CVAL_BITS  = 16;
    localparam int TOTAL_BITS = 23;
    localparam int SUM_W      = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = '1;
    localparam logic [TIME_BITS-1:0]  PERIOD_RESET = TIME_BITS'(1 * 1000);
    localparam logic [TIME_BITS-1:0]  WINDOW_RESET = TIME_BITS'(75 * 1000);

    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [1:0] {
        ACT_POLL   = 2'd0,
        ACT_LATEST = 2'd1,
        ACT_WINDOW = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LATEST,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef enum logic {
        REG_PERIOD = 1'b0,
        REG_WINDOW = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic clear;
        logic step;
    } t_walk_ctrl;

    function automatic t_slot prev_slot(input t_slot s);
        return (s == '0) ? SLOT_W'(RING_DEPTH - 1) : s - SLOT_W'(1);
    endfunction

    function automatic t_slot next_slot(input t_slot s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

// ===== design/pivwc_ram.sv =====
`timescale 1ns / 1ps

module pivwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pivwc_walk_unit.sv =====
`timescale 1ns / 1ps

module pivwc_walk_unit import pivwc_pkg::*; (
    input  logic                  i_clk,
    input  t_walk_ctrl            i_ctrl,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [TIME_BITS-1:0]  i_start,
    input  logic [TIME_BITS-1:0]  i_newest_end,
    input  logic [TIME_BITS-1:0]  i_window,
    output logic [TOTAL_BITS-1:0] o_sum_next,
    output logic [TIME_BITS-1:0]  o_diff,
    output logic                  o_in_window
);

    logic [TOTAL_BITS-1:0] r_sum;
    logic [TOTAL_BITS-1:0] n_sum;
    logic [SUM_W-1:0]      w_raw;

    // saturating accumulate, one entry per step
    always_comb begin
        w_raw = SUM_W'(r_sum) + SUM_W'(i_count);
        if (w_raw > SUM_W'(TOTAL_MAX)) begin
            n_sum = TOTAL_MAX;
        end else begin
            n_sum = w_raw[TOTAL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_sum <= '0;
        end else if (i_ctrl.step) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_next  = n_sum;
    assign o_diff      = i_newest_end - i_start;
    assign o_in_window = (o_diff <= i_window);

endmodule

// ===== design/pulse_interval_window_counter.sv =====
`timescale 1ns / 1ps

// Dosimeter pulse-count logger. One input transfer carries an action in tuser
// (poll, read latest, read window) and the current millisecond time and counter
// reading in tdata; every input transfer yields exactly one output transfer.
// A poll goes from idle straight to the emit state, a read of the latest interval
// passes the latest state first, and a window read walks the ring newest first
// through up to 128 entries, one at a time through the single read port of the
// interval ring. An empty ring goes straight to emit. tready is low while an
// item is at work; the result sits in an output register so the next item is
// taken while it waits. No clearing pass follows reset. Configuration writes
// must only occur while the block is idle.
module pulse_interval_window_counter import pivwc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // now_ms[31:0], counter_value[47:32]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pulse_total[22:0], span_ms[54:23], stamp_ms[86:55]
    output logic [1:0]  m_axis_tuser    // closed_interval[0], data_present[1]
);

    t_state r_state, n_state;

    t_slot                 r_head;
    t_slot                 r_w;
    logic [STORED_W-1:0]   r_stored;
    logic [STORED_W-1:0]   r_visited;
    logic [TIME_BITS-1:0]  r_last_close;
    logic [TIME_BITS-1:0]  r_open_start;
    logic                  r_start0_zero;
    logic [TIME_BITS-1:0]  r_period;
    logic [TIME_BITS-1:0]  r_window;

    logic                  r_res_closed;
    logic                  r_res_present;
    logic [TOTAL_BITS-1:0] r_res_total;
    logic [TIME_BITS-1:0]  r_res_span;
    logic [TIME_BITS-1:0]  r_res_stamp;

    logic                  r_out_valid;
    logic                  r_out_closed;
    logic                  r_out_present;
    logic [TOTAL_BITS-1:0] r_out_total;
    logic [TIME_BITS-1:0]  r_out_span;
    logic [TIME_BITS-1:0]  r_out_stamp;

    t_action               w_action;
    logic [TIME_BITS-1:0]  w_now;
    logic [COUNT_BITS-1:0] w_reading;
    logic                  w_accept;
    logic                  w_is_read;
    logic                  w_close;
    logic                  w_more;
    logic                  w_load_out;
    t_slot                 w_raddr;
    t_walk_ctrl            w_ctrl;

    logic [TIME_BITS-1:0]  w_start_ram;
    logic [TIME_BITS-1:0]  w_start_rd;
    logic [COUNT_BITS-1:0] w_count_rd;
    logic [COUNT_BITS-1:0] w_count_use;
    logic [TOTAL_BITS-1:0] w_count_ext;
    logic [TOTAL_BITS-1:0] w_sum_next;
    logic [TIME_BITS-1:0]  w_diff;
    logic                  w_in_window;

    assign w_action  = t_action'(s_axis_tuser[1:0]);
    assign w_now     = s_axis_tdata[31:0];
    assign w_reading = COUNT_BITS'(s_axis_tdata[CVAL_BITS+31:32]);
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_is_read = (w_action == ACT_LATEST) || (w_action == ACT_WINDOW);
    assign w_close   = w_accept && (w_action == ACT_POLL)
                       && ((w_now - r_open_start) > r_period);
    assign w_more    = ((r_visited + STORED_W'(1)) < r_stored) && w_in_window;

    // slot 0 holds start time zero until it is first written
    assign w_start_rd  = (r_w == '0 && r_start0_zero) ? '0 : w_start_ram;
    // the open slot counts nothing until it is closed
    assign w_count_use = (r_w == r_head) ? '0 : w_count_rd;
    assign w_count_ext = TOTAL_BITS'(w_count_rd);

    pivwc_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (RING_DEPTH)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_close),
        .i_waddr (next_slot(r_head)),
        .i_wdata (w_now),
        .i_raddr (w_raddr),
        .o_rdata (w_start_ram)
    );

    pivwc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (RING_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_close),
        .i_waddr (r_head),
        .i_wdata (w_reading),
        .i_raddr (w_raddr),
        .o_rdata (w_count_rd)
    );

    pivwc_walk_unit u_walk (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_count      (w_count_use),
        .i_start      (w_start_rd),
        .i_newest_end (r_last_close),
        .i_window     (r_window),
        .o_sum_next   (w_sum_next),
        .o_diff       (w_diff),
        .o_in_window  (w_in_window)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        ACT_LATEST: n_state = (r_stored == '0) ? ST_EMIT : ST_LATEST;
                        ACT_WINDOW: n_state = (r_stored == '0) ? ST_EMIT : ST_WALK;
                        default:    n_state = ST_EMIT;
                    endcase
                end
            end
            ST_LATEST: n_state = ST_EMIT;
            ST_WALK: begin
                if (!w_more) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctrl        = '0;
        w_raddr       = prev_slot(r_head);
        w_load_out    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctrl.clear  = w_accept;
            end
            ST_LATEST: begin
                w_ctrl.step = 1'b1;
            end
            ST_WALK: begin
                w_ctrl.step = 1'b1;
                w_raddr     = prev_slot(r_w);
            end
            ST_EMIT: begin
                w_load_out = !r_out_valid || m_axis_tready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_stored      <= '0;
            r_last_close  <= '0;
            r_open_start  <= '0;
            r_start0_zero <= 1'b1;
            r_period      <= PERIOD_RESET;
            r_window      <= WINDOW_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_PERIOD: r_period <= i_cfg_wdata;
                    REG_WINDOW: r_window <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_close) begin
                r_head       <= next_slot(r_head);
                r_last_close <= w_now;
                r_open_start <= w_now;
                if (r_stored < STORED_W'(RING_DEPTH)) begin
                    r_stored <= r_stored + STORED_W'(1);
                end
                if (next_slot(r_head) == '0) begin
                    r_start0_zero <= 1'b0;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_w           <= prev_slot(r_head);
            r_visited     <= '0;
            r_res_closed  <= w_close;
            r_res_present <= w_is_read && (r_stored != '0);
            r_res_total   <= '0;
            r_res_span    <= '0;
            if (w_is_read) begin
                r_res_stamp <= (r_stored == '0) ? w_now : r_last_close;
            end else begin
                r_res_stamp <= '0;
            end
        end
        if (r_state == ST_LATEST) begin
            r_res_total <= w_count_ext;
            r_res_span  <= w_diff;
        end
        if (r_state == ST_WALK) begin
            r_visited <= r_visited + STORED_W'(1);
            r_w       <= prev_slot(r_w);
            if (!w_more) begin
                r_res_total <= w_sum_next;
                r_res_span  <= w_diff;
            end
        end
        if (w_load_out) begin
            r_out_closed  <= r_res_closed;
            r_out_present <= r_res_present;
            r_out_total   <= r_res_total;
            r_out_span    <= r_res_span;
            r_out_stamp   <= r_res_stamp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_stamp, r_out_span, r_out_total};
    assign m_axis_tuser  = {r_out_present, r_out_closed};

endmodule

// ===== design/pivwc_checker.sv =====
`timescale 1ns / 1ps

`include "pulse_interval_window_counter_assert.svh"

module pivwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // stalled result stays offered
    `PIVWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a transfer in keeps the input side closed for the next cycle
    `PIVWC_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a result is either a poll result or a read result
    `PIVWC_ASSERT_NOW(a_flag_excl, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))

    // without stored data there is no count and no span
    `PIVWC_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[54:0] == 55'd0)

endmodule

bind pulse_interval_window_counter pivwc_checker u_checker (.*);
